// ===== rtl/echo_distance_median_macros.svh =====
// assertion macros for the echo distance median block
// used by the top level only; no other dependencies
`ifndef ECHO_DISTANCE_MEDIAN_MACROS_SVH
`define ECHO_DISTANCE_MEDIAN_MACROS_SVH

// same-cycle implication, disabled during reset
`define EDM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("edm check failed");

// next-cycle implication, disabled during reset
`define EDM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("edm check failed");

`endif

// ===== rtl/edm_pkg.sv =====
// shared constants, types and command/status structs for echo_distance_median
// no dependencies
package edm_pkg;

    localparam int WINDOW    = 5;
    localparam int TICK_BITS = 16;
    localparam int SPEED_W   = 12;
    localparam int CM_W      = 14;
    localparam logic [CM_W-1:0] CM_MAX = {CM_W{1'b1}};
    localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd343;

    // echo time times speed, then divided by 20000 = 32 * 625
    localparam int PROD_W   = TICK_BITS + SPEED_W;
    localparam int PRE_SH   = 5;
    localparam int PRE_W    = PROD_W - PRE_SH;
    localparam int RK       = PRE_W + 10;
    localparam longint unsigned RECIP = ((64'd1 << RK) + 64'd624) / 64'd625;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int SCALED_W = PRE_W + RECIP_W;
    localparam int QUOT_W   = SCALED_W - RK;

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PH_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SAT,
        ST_WRITE,
        ST_SORT,
        ST_MED,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic clear;
        logic mul_a;
        logic mul_b;
        logic sat;
        logic write;
        logic sort_step;
        logic sort_odd;
        logic med;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic restart;
        logic last_fill;
    } t_dp_status;

endpackage

// ===== rtl/edm_datapath.sv =====
// datapath: tick difference, scaling to centimetres, window store,
// odd-even transposition sort, median and output register; uses edm_pkg
module edm_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  edm_pkg::t_dp_cmd            i_cmd,
    output edm_pkg::t_dp_status         o_status,
    input  logic                        i_cfg_we,
    input  logic [edm_pkg::SPEED_W-1:0] i_cfg_data,
    input  logic                        i_action,
    input  logic [edm_pkg::TICK_BITS-1:0] i_echo_start_tick,
    input  logic [edm_pkg::TICK_BITS-1:0] i_echo_end_tick,
    output logic [edm_pkg::CM_W-1:0]    o_sample_cm,
    output logic [edm_pkg::CM_W-1:0]    o_median_cm,
    output logic                        o_median_new
);
    import edm_pkg::*;

    localparam int MID = WINDOW / 2;

    logic [SPEED_W-1:0]   r_speed;
    logic                 r_restart;
    logic [TICK_BITS-1:0] r_dt;
    logic [PROD_W-1:0]    r_prod;
    logic [SCALED_W-1:0]  r_scaled;
    logic [CM_W-1:0]      r_sample;
    logic [CM_W-1:0]      r_win [WINDOW];
    logic [CM_W-1:0]      n_win [WINDOW];
    logic [FILL_W-1:0]    r_fill;
    logic [CM_W-1:0]      r_held;
    logic                 r_fresh;
    logic [CM_W-1:0]      r_o_sample;
    logic [CM_W-1:0]      r_o_median;
    logic                 r_o_new;
    logic [QUOT_W-1:0]    quot;
    logic [CM_W-1:0]      median;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_RESET;
        end else if (i_cfg_we) begin
            r_speed <= i_cfg_data;
        end
    end

    assign quot = r_scaled[SCALED_W-1:RK];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_restart <= i_action;
            r_dt      <= TICK_BITS'(i_echo_end_tick - i_echo_start_tick);
        end
        if (i_cmd.mul_a) begin
            r_prod <= PROD_W'(r_dt) * PROD_W'(r_speed);
        end
        if (i_cmd.mul_b) begin
            r_scaled <= SCALED_W'(r_prod[PROD_W-1:PRE_SH]) * SCALED_W'(RECIP);
        end
        if (i_cmd.clear) begin
            r_sample <= '0;
        end else if (i_cmd.sat) begin
            // quotient is floor(prod / 20000); saturate to the field range
            if (QUOT_W'(CM_MAX) < quot && QUOT_W > CM_W) begin
                r_sample <= CM_MAX;
            end else begin
                r_sample <= CM_W'(quot);
            end
        end
    end

    // window entries: one write per sample, compare-swap lanes while sorting
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            n_win[i] = r_win[i];
        end
        if (i_cmd.write) begin
            n_win[r_fill[IDX_W-1:0]] = r_sample;
        end
        if (i_cmd.sort_step) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                if ((i % 2 == 1) == i_cmd.sort_odd && r_win[i] > r_win[i+1]) begin
                    n_win[i]   = r_win[i+1];
                    n_win[i+1] = r_win[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < WINDOW; i++) begin
            r_win[i] <= n_win[i];
        end
    end

    generate
        if (WINDOW % 2 == 1) begin : g_odd
            assign median = r_win[MID];
        end else begin : g_even
            logic [CM_W:0] pair_sum;
            assign pair_sum = {1'b0, r_win[MID-1]} + {1'b0, r_win[MID]};
            assign median   = pair_sum[CM_W:1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_held <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_fill <= '0;
                r_held <= '0;
            end else begin
                if (i_cmd.write) begin
                    if (o_status.last_fill) begin
                        r_fill <= '0;
                    end else begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                end
                if (i_cmd.med) begin
                    r_held <= median;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_fresh <= 1'b0;
        end else if (i_cmd.med) begin
            r_fresh <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_sample <= r_sample;
            r_o_median <= r_held;
            r_o_new    <= r_fresh;
        end
    end

    assign o_status.restart   = r_restart;
    assign o_status.last_fill = (r_fill == FILL_W'(WINDOW - 1));

    assign o_sample_cm  = r_o_sample;
    assign o_median_cm  = r_o_median;
    assign o_median_new = r_o_new;

endmodule

// ===== rtl/edm_ctrl.sv =====
// controller: sequences one item through the datapath and owns both handshakes
// uses edm_pkg
module edm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output edm_pkg::t_dp_cmd    o_cmd,
    input  edm_pkg::t_dp_status i_status
);
    import edm_pkg::*;

    t_state          r_state, n_state;
    logic [PH_W-1:0] r_phase, n_phase;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        o_cmd.sort_odd = r_phase[0];
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                if (i_status.restart) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_DONE;
                end else begin
                    o_cmd.mul_a = 1'b1;
                    n_state     = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = ST_SAT;
            end
            ST_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_phase     = '0;
                n_state     = i_status.last_fill ? ST_SORT : ST_DONE;
            end
            ST_SORT: begin
                // WINDOW alternating phases fully sort the window
                o_cmd.sort_step = 1'b1;
                if (r_phase == PH_W'(WINDOW - 1)) begin
                    n_state = ST_MED;
                end else begin
                    n_phase = r_phase + PH_W'(1);
                end
            end
            ST_MED: begin
                o_cmd.med = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/echo_distance_median.sv =====
// echo_distance_median: one item at a time; a restart, a sample that leaves the window
// partly filled and one that fills it take successively longer paths, the odd-even sort
// on a full window being the longest; a finished result sits in the output register
// while the next item is taken
// synchronous active-low reset: fill count, held median, handshakes cleared,
// sound speed back to 343
module echo_distance_median (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [edm_pkg::SPEED_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [edm_pkg::TICK_BITS-1:0] i_echo_start_tick,
    input  logic [edm_pkg::TICK_BITS-1:0] i_echo_end_tick,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [edm_pkg::CM_W-1:0]      o_sample_cm,
    output logic [edm_pkg::CM_W-1:0]      o_median_cm,
    output logic                          o_median_new
);
    import edm_pkg::*;

`include "echo_distance_median_macros.svh"

    t_dp_cmd    cmd;
    t_dp_status status;

    edm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    edm_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_echo_start_tick (i_echo_start_tick),
        .i_echo_end_tick   (i_echo_end_tick),
        .o_sample_cm       (o_sample_cm),
        .o_median_cm       (o_median_cm),
        .o_median_new      (o_median_new)
    );

    // block is busy in the cycle after it takes an item
    `EDM_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a result waiting downstream is never overwritten
    `EDM_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, !o_out_valid || !i_out_stall)
    // median is taken only straight after the last sort phase
    `EDM_ASSERT_IMP(a_med_after_sort, i_clk, i_rst_n, cmd.med, $past(cmd.sort_step))

endmodule
